// ===== hdl/relative_strength_index_macros.svh =====
// ----------------------------------------------------------------------------
// relative strength index assertion macros
// implication checks on i_clk with reset i_rst_n, empty under SYNTH
// ----------------------------------------------------------------------------
`ifndef RELATIVE_STRENGTH_INDEX_MACROS_SVH
`define RELATIVE_STRENGTH_INDEX_MACROS_SVH

`ifndef SYNTH
`define RSI_ASSERT_IMP(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error(msg);
`define RSI_ASSERT_NXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error(msg);
`else
`define RSI_ASSERT_IMP(lbl, ant, con, msg)
`define RSI_ASSERT_NXT(lbl, ant, con, msg)
`endif

`endif

// ===== hdl/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// widths, constants and shared types of the relative strength index block
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

    localparam int PRICE_W  = 32;
    localparam int PERIOD_W = 8;
    localparam int CHG_W    = 48;
    localparam int AVG_W    = 56;
    localparam int ACC_W    = 64;
    localparam int SUM_W    = 57;
    localparam int SCL_W    = 61;
    localparam int RSI_W    = 23;
    localparam int FRAC_PAD = 18;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;
    localparam logic [RSI_W-1:0]    RSI_NO_LOSS  = 23'd6488712;
    localparam logic [RSI_W-1:0]    RSI_MAX      = 23'd6553600;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

`default_nettype wire

// ===== hdl/relative_strength_index.sv =====
// ----------------------------------------------------------------------------
// relative_strength_index
// wilder relative strength index over a stream of q16.16 prices
// ----------------------------------------------------------------------------
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-------------------------------
//  input    | i_valid / o_stall              | i_price, i_new_series
//  output   | o_valid / i_stall              | o_rsi_value
//  config   | i_cfg_wr_en                    | i_cfg_wr_data (rsi_period)
//
//  a restart or warm-up price is taken in the idle state; an item that gives an
//  index passes the 8-step multiply (only after warm-up), the 64-step serial
//  divide by the period, a scale step and the 23-step ratio divide, which is
//  skipped when the loss average is zero
//  synchronous active-low reset, no clearing pass; o_stall is high while an
//  item is in work, and a held result waits in the output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "relative_strength_index_macros.svh"

module relative_strength_index (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [rsi_pkg::PERIOD_W-1:0]  i_cfg_wr_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [rsi_pkg::PRICE_W-1:0]   i_price,
    input  wire logic                          i_new_series,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [rsi_pkg::RSI_W-1:0]          o_rsi_value
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MAC    = 3'd1;
    localparam logic [2:0] S_DIVP   = 3'd2;
    localparam logic [2:0] S_SCALE  = 3'd3;
    localparam logic [2:0] S_RSTART = 3'd4;
    localparam logic [2:0] S_RATIO  = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0]                     r_state;
    logic [rsi_pkg::PERIOD_W-1:0]   r_period;
    logic [rsi_pkg::PRICE_W-1:0]    r_last;
    logic                           r_have;
    logic [rsi_pkg::PERIOD_W-1:0]   r_cnt;
    logic [rsi_pkg::AVG_W-1:0]      r_g;
    logic [rsi_pkg::AVG_W-1:0]      r_l;
    logic [rsi_pkg::SCL_W-1:0]      r_g25;
    logic [rsi_pkg::SUM_W-1:0]      r_sum;
    logic [rsi_pkg::RSI_W-1:0]      r_res;
    logic                           r_o_valid;
    logic [rsi_pkg::RSI_W-1:0]      r_o_rsi;

    logic                           accept;
    logic                           restart;
    logic [rsi_pkg::PERIOD_W-1:0]   p_eff;
    logic [rsi_pkg::PERIOD_W-1:0]   pm1;
    logic [rsi_pkg::PERIOD_W-1:0]   cnt_n;
    logic [rsi_pkg::PRICE_W-1:0]    up;
    logic [rsi_pkg::PRICE_W-1:0]    dn;
    logic [rsi_pkg::CHG_W-1:0]      gx;
    logic [rsi_pkg::CHG_W-1:0]      lx;
    logic [rsi_pkg::AVG_W-1:0]      sum_g;
    logic [rsi_pkg::AVG_W-1:0]      sum_l;
    logic                           warm;
    logic                           warm_last;
    logic                           mac_start;
    logic                           divp_start;
    logic                           ratio_start;
    logic                           out_free;
    logic [rsi_pkg::ACC_W-1:0]      num_g;
    logic [rsi_pkg::ACC_W-1:0]      num_l;
    logic [rsi_pkg::SCL_W-1:0]      g_ext;

    rsi_pkg::t_unit_stat            mac_g_stat;
    rsi_pkg::t_unit_stat            mac_l_stat;
    rsi_pkg::t_unit_stat            div_g_stat;
    rsi_pkg::t_unit_stat            div_l_stat;
    rsi_pkg::t_unit_stat            ratio_stat;
    logic [rsi_pkg::ACC_W-1:0]      mac_g_acc;
    logic [rsi_pkg::ACC_W-1:0]      mac_l_acc;
    logic [rsi_pkg::ACC_W-1:0]      quo_g;
    logic [rsi_pkg::ACC_W-1:0]      quo_l;
    logic [rsi_pkg::RSI_W-1:0]      quo_r;

    assign accept    = i_valid && !o_stall;
    assign restart   = i_new_series || !r_have;
    assign p_eff     = (r_period == '0) ? rsi_pkg::PERIOD_W'(1) : r_period;
    assign pm1       = p_eff - rsi_pkg::PERIOD_W'(1);
    assign cnt_n     = r_cnt + rsi_pkg::PERIOD_W'(1);
    assign up        = (i_price > r_last) ? i_price - r_last : '0;
    assign dn        = (i_price < r_last) ? r_last - i_price : '0;
    assign gx        = {up, 16'b0};
    assign lx        = {dn, 16'b0};
    assign sum_g     = r_g + {{(rsi_pkg::AVG_W-rsi_pkg::CHG_W){1'b0}}, gx};
    assign sum_l     = r_l + {{(rsi_pkg::AVG_W-rsi_pkg::CHG_W){1'b0}}, lx};
    assign warm      = r_cnt < p_eff;
    assign warm_last = cnt_n >= p_eff;

    assign mac_start   = accept && !restart && !warm;
    assign divp_start  = (accept && !restart && warm && warm_last) ||
                         (r_state == S_MAC && mac_g_stat.done);
    assign ratio_start = (r_state == S_RSTART) && (r_l != '0);
    assign out_free    = !r_o_valid || !i_stall;

    assign num_g = (r_state == S_MAC) ? mac_g_acc :
                   {{(rsi_pkg::ACC_W-rsi_pkg::AVG_W){1'b0}}, sum_g};
    assign num_l = (r_state == S_MAC) ? mac_l_acc :
                   {{(rsi_pkg::ACC_W-rsi_pkg::AVG_W){1'b0}}, sum_l};
    assign g_ext = {{(rsi_pkg::SCL_W-rsi_pkg::AVG_W){1'b0}}, r_g};

    rsi_mac u_mac_g (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mac_start),
        .i_mcand  (r_g),
        .i_mplr   (pm1),
        .i_addend (gx),
        .o_stat   (mac_g_stat),
        .o_acc    (mac_g_acc)
    );

    rsi_mac u_mac_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mac_start),
        .i_mcand  (r_l),
        .i_mplr   (pm1),
        .i_addend (lx),
        .o_stat   (mac_l_stat),
        .o_acc    (mac_l_acc)
    );

    rsi_div #(.DVD_W(rsi_pkg::ACC_W), .DVR_W(rsi_pkg::PERIOD_W)) u_div_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (divp_start),
        .i_rem   ('0),
        .i_dvd   (num_g),
        .i_dvr   (p_eff),
        .o_stat  (div_g_stat),
        .o_quo   (quo_g)
    );

    rsi_div #(.DVD_W(rsi_pkg::ACC_W), .DVR_W(rsi_pkg::PERIOD_W)) u_div_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (divp_start),
        .i_rem   ('0),
        .i_dvd   (num_l),
        .i_dvr   (p_eff),
        .o_stat  (div_l_stat),
        .o_quo   (quo_l)
    );

    rsi_div #(.DVD_W(rsi_pkg::RSI_W), .DVR_W(rsi_pkg::SUM_W)) u_div_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ratio_start),
        .i_rem   ({1'b0, r_g25[rsi_pkg::SCL_W-1:5]}),
        .i_dvd   ({r_g25[4:0], {rsi_pkg::FRAC_PAD{1'b0}}}),
        .i_dvr   (r_sum),
        .o_stat  (ratio_stat),
        .o_quo   (quo_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_period  <= rsi_pkg::PERIOD_RESET;
            r_last    <= '0;
            r_have    <= 1'b0;
            r_cnt     <= '0;
            r_g       <= '0;
            r_l       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && !i_stall && r_state != S_EMIT) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
                r_have   <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last <= i_price;
                        if (restart) begin
                            r_have <= 1'b1;
                            r_cnt  <= '0;
                            r_g    <= '0;
                            r_l    <= '0;
                        end else if (warm) begin
                            r_cnt <= cnt_n;
                            r_g   <= sum_g;
                            r_l   <= sum_l;
                            if (warm_last) begin
                                r_state <= S_DIVP;
                            end
                        end else begin
                            r_state <= S_MAC;
                        end
                    end
                end
                S_MAC: begin
                    if (mac_g_stat.done) begin
                        r_state <= S_DIVP;
                    end
                end
                S_DIVP: begin
                    if (div_g_stat.done) begin
                        r_g     <= quo_g[rsi_pkg::AVG_W-1:0];
                        r_l     <= quo_l[rsi_pkg::AVG_W-1:0];
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_g25   <= (g_ext << 4) + (g_ext << 3) + g_ext;
                    r_sum   <= {1'b0, r_g} + {1'b0, r_l};
                    r_state <= S_RSTART;
                end
                S_RSTART: begin
                    if (r_l == '0) begin
                        r_res   <= rsi_pkg::RSI_NO_LOSS;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_RATIO;
                    end
                end
                S_RATIO: begin
                    if (ratio_stat.done) begin
                        r_res   <= quo_r;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_rsi   <= r_res;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_rsi_value = r_o_rsi;

    `RSI_ASSERT_IMP(a_cnt_bound, r_have, r_cnt <= p_eff, "change count above period")
    `RSI_ASSERT_IMP(a_rsi_range, r_o_valid, r_o_rsi <= rsi_pkg::RSI_MAX, "index above 100")
    `RSI_ASSERT_NXT(a_emit_out, r_state == S_EMIT && out_free, r_o_valid,
        "finished result not presented")
    `RSI_ASSERT_IMP(a_lanes_agree, 1'b1, mac_l_stat == mac_g_stat && div_l_stat == div_g_stat,
        "gain and loss lanes out of step")

endmodule

`default_nettype wire

// ===== hdl/rsi_mac.sv =====
// ----------------------------------------------------------------------------
// rsi_mac
// serial multiply-add: addend + multiplicand * multiplier, one multiplier bit
// per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_mac (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [rsi_pkg::AVG_W-1:0]     i_mcand,
    input  wire logic [rsi_pkg::PERIOD_W-1:0]  i_mplr,
    input  wire logic [rsi_pkg::CHG_W-1:0]     i_addend,
    output rsi_pkg::t_unit_stat                o_stat,
    output logic [rsi_pkg::ACC_W-1:0]          o_acc
);

    localparam int CNT_W = $clog2(rsi_pkg::PERIOD_W + 1);

    logic [rsi_pkg::ACC_W-1:0]    r_mcand;
    logic [rsi_pkg::PERIOD_W-1:0] r_mplr;
    logic [rsi_pkg::ACC_W-1:0]    r_acc;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_busy;
    logic                         r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= CNT_W'(rsi_pkg::PERIOD_W);
                r_mcand <= {{(rsi_pkg::ACC_W-rsi_pkg::AVG_W){1'b0}}, i_mcand};
                r_mplr  <= i_mplr;
                r_acc   <= {{(rsi_pkg::ACC_W-rsi_pkg::CHG_W){1'b0}}, i_addend};
            end else if (r_busy) begin
                if (r_mplr[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand <= {r_mcand[rsi_pkg::ACC_W-2:0], 1'b0};
                r_mplr  <= {1'b0, r_mplr[rsi_pkg::PERIOD_W-1:1]};
                r_cnt   <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_acc       = r_acc;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

// ===== hdl/rsi_div.sv =====
// ----------------------------------------------------------------------------
// rsi_div
// bit-serial restoring divider, one quotient bit per cycle, with a preset
// partial remainder
// ----------------------------------------------------------------------------
`default_nettype none

`include "relative_strength_index_macros.svh"

module rsi_div #(
    parameter int DVD_W = 64,
    parameter int DVR_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVR_W-1:0] i_rem,
    input  wire logic [DVD_W-1:0] i_dvd,
    input  wire logic [DVR_W-1:0] i_dvr,
    output rsi_pkg::t_unit_stat   o_stat,
    output logic [DVD_W-1:0]      o_quo
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVR_W-1:0] r_rem;
    logic [DVD_W-1:0] r_dvd;
    logic [DVD_W-1:0] r_quo;
    logic [DVR_W-1:0] r_dvr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVR_W:0]   trial;
    logic             ge;
    logic [DVR_W:0]   diff;

    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign ge    = trial >= {1'b0, r_dvr};
    assign diff  = trial - {1'b0, r_dvr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
                r_rem  <= i_rem;
                r_dvd  <= i_dvd;
                r_dvr  <= i_dvr;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], ge};
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_quo       = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    `RSI_ASSERT_NXT(a_done_pulse, r_done, !r_done, "divider done longer than one cycle")
    `RSI_ASSERT_IMP(a_no_restart, i_start, !r_busy, "divider started while busy")
    `RSI_ASSERT_IMP(a_rem_below, r_busy, r_rem < r_dvr, "partial remainder not below divisor")

endmodule

`default_nettype wire

// ===== sim/rsi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_checker
// watches the price and index channels and the period register, predicts
// each index with a wilder smoothing model and compares in order
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [rsi_pkg::PERIOD_W-1:0]  i_cfg_wr_data,
    input  wire logic                          i_valid,
    input  wire logic                          i_stall_in,
    input  wire logic [rsi_pkg::PRICE_W-1:0]   i_price,
    input  wire logic                          i_new_series,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic [rsi_pkg::RSI_W-1:0]     i_rsi_value,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    logic [rsi_pkg::PERIOD_W-1:0] period_reg;
    logic [rsi_pkg::PRICE_W-1:0]  prev_price;
    logic                         prev_ok;
    logic [rsi_pkg::PERIOD_W-1:0] warm_count;
    logic [rsi_pkg::AVG_W-1:0]    gain_avg;
    logic [rsi_pkg::AVG_W-1:0]    loss_avg;
    logic [rsi_pkg::RSI_W-1:0]    index_queue[$];

    function automatic logic [rsi_pkg::RSI_W-1:0] strength(
        logic [rsi_pkg::AVG_W-1:0] g, logic [rsi_pkg::AVG_W-1:0] l);
        logic [127:0] num;
        logic [127:0] den;
        if (l == 0) return rsi_pkg::RSI_NO_LOSS;
        num = 128'(g) * 128'd6553600;
        den = 128'(g) + 128'(l);
        return rsi_pkg::RSI_W'(num / den);
    endfunction

    task automatic take_price(logic [rsi_pkg::PRICE_W-1:0] p, logic restart);
        logic [63:0]  per;
        logic [rsi_pkg::AVG_W-1:0] gx;
        logic [rsi_pkg::AVG_W-1:0] lx;
        logic [127:0] t;
        per = (period_reg == 0) ? 64'd1 : 64'(period_reg);
        if (restart || !prev_ok) begin
            prev_price = p;
            prev_ok = 1'b1;
            warm_count = 0;
            gain_avg = 0;
            loss_avg = 0;
            return;
        end
        gx = (p > prev_price) ? rsi_pkg::AVG_W'(p - prev_price) << 16 : '0;
        lx = (p < prev_price) ? rsi_pkg::AVG_W'(prev_price - p) << 16 : '0;
        prev_price = p;
        if (64'(warm_count) < per) begin
            gain_avg = gain_avg + gx;
            loss_avg = loss_avg + lx;
            warm_count++;
            if (64'(warm_count) < per) return;
            gain_avg = rsi_pkg::AVG_W'(64'(gain_avg) / per);
            loss_avg = rsi_pkg::AVG_W'(64'(loss_avg) / per);
        end else begin
            t = (128'(gain_avg) * 128'(per - 1) + 128'(gx)) / 128'(per);
            gain_avg = rsi_pkg::AVG_W'(t);
            t = (128'(loss_avg) * 128'(per - 1) + 128'(lx)) / 128'(per);
            loss_avg = rsi_pkg::AVG_W'(t);
        end
        index_queue.insert(index_queue.size(), strength(gain_avg, loss_avg));
    endtask

    always @(posedge i_clk) begin
        logic [rsi_pkg::RSI_W-1:0] exp_val;
        if (!i_rst_n) begin
            period_reg = rsi_pkg::PERIOD_RESET;
            prev_ok = 1'b0;
            prev_price = 0;
            warm_count = 0;
            gain_avg = 0;
            loss_avg = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (index_queue.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected index transaction: %0d", i_rsi_value);
                end else begin
                    exp_val = index_queue.pop_front();
                    if (exp_val !== i_rsi_value) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("index mismatch: expected %0d actual %0d",
                                     exp_val, i_rsi_value);
                    end
                end
            end
            if (i_cfg_wr_en) begin
                period_reg = i_cfg_wr_data;
                prev_ok = 1'b0;
            end
            if (i_valid && !i_stall_in) take_price(i_price, i_new_series);
        end
        o_pending <= index_queue.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end
endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the relative strength index block: directed price runs,
// random walks under several periods, random idling and a long output stall
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_wr_en = 1'b0;
    logic [rsi_pkg::PERIOD_W-1:0] i_cfg_wr_data = '0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic [rsi_pkg::PRICE_W-1:0]  i_price = '0;
    logic                         i_new_series = 1'b0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic [rsi_pkg::RSI_W-1:0]    o_rsi_value;
    int                           fail_count;
    int                           pending;
    int                           quiet_cycles = 0;
    bit                           calm = 1'b0;
    bit                           hold_off = 1'b0;
    logic [rsi_pkg::PRICE_W-1:0]  walk = 32'h0100_0000;

    always #5 i_clk = ~i_clk;

    relative_strength_index dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_price(i_price), .i_new_series(i_new_series),
        .o_valid(o_valid), .i_stall(i_stall), .o_rsi_value(o_rsi_value)
    );

    rsi_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid(i_valid), .i_stall_in(o_stall),
        .i_price(i_price), .i_new_series(i_new_series),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_rsi_value(o_rsi_value),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    task automatic send_price(logic [rsi_pkg::PRICE_W-1:0] p, logic restart);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_price <= p;
        i_new_series <= restart;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (o_stall || o_valid || pending != 0) @(posedge i_clk);
    endtask

    task automatic set_period(logic [rsi_pkg::PERIOD_W-1:0] v);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic walk_series(int n, int step_bits);
        int k;
        send_price(walk, 1'b1);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 1)) walk = walk + $urandom_range(0, (1 << step_bits) - 1);
            else walk = walk - $urandom_range(0, (1 << step_bits) - 1);
            send_price($urandom_range(0, 40) == 0 ? $urandom() : walk,
                       $urandom_range(0, 60) == 0);
        end
    endtask

    always @(posedge i_clk) begin
        if (!calm && !hold_off && $urandom_range(0, 4) == 0) begin
            i_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_stall <= hold_off;
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int k;
        int r;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: extremes, flat, period one, zero period
        send_price(32'h0, 1'b0);
        for (k = 0; k < 15; k++) send_price(k[0] ? 32'hFFFF_FFFF : 32'h0, 1'b0);
        send_price(32'h1234_5678, 1'b1);
        send_price(32'h1234_5678, 1'b0);
        set_period(8'd1);
        send_price(32'h0, 1'b0);
        send_price(32'h0, 1'b0);
        send_price(32'hFFFF_FFFF, 1'b0);
        send_price(32'h0, 1'b0);
        set_period(8'd0);
        send_price(32'h5, 1'b0);
        send_price(32'h3, 1'b0);
        send_price(32'h9, 1'b0);
        // long output hold-off while the sender keeps offering
        set_period(8'd2);
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            walk_series(8, 16);
        join
        for (r = 0; r < 8; r++) begin
            case (r)
                0: set_period(8'd255);
                1: set_period(8'd14);
                2: set_period(8'd1);
                default: set_period(8'($urandom_range(0, 30)));
            endcase
            walk = $urandom();
            if (r >= 6) calm = 1'b1;
            walk_series(r == 0 ? 300 : 150, $urandom_range(4, 24));
        end
        drain();
        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule

`default_nettype wire

// ===== relative_strength_index.f =====
+incdir+hdl
hdl/rsi_pkg.sv
hdl/rsi_mac.sv
hdl/rsi_div.sv
hdl/relative_strength_index.sv
sim/rsi_checker.sv
sim/tb.sv
